@@ sv/assert_macros.svh @@
// Assertion macros shared by the decoder RTL.
// Depends on nothing; expects clk and arst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define VSFD_ASSERT(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("vsfd assertion failed");
`define VSFD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vsfd assertion failed");
`else
`define VSFD_ASSERT(lbl, expr)
`define VSFD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ sv/vsfd_pkg.sv @@
// Constants and types for the vital sign frame decoder.
// No dependencies.
package vsfd_pkg;

	localparam logic [7:0] SYNC_BYTE   = 8'h55;
	localparam logic [7:0] CLASS_VITAL = 8'h05;
	localparam logic [7:0] GROUP_RESP  = 8'h01;
	localparam logic [7:0] GROUP_HEART = 8'h06;
	localparam logic [7:0] ITEM_RATE   = 8'h01;
	localparam logic [7:0] ITEM_BREATH = 8'h04;
	localparam logic [7:0] COUNT_MAX   = 8'hFF;

	localparam int CAP_DEPTH   = 4;
	localparam int CAP_FIRST   = 3;
	localparam int TDATA_W     = 24;

	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_RESP   = 2'd1,
		KIND_BREATH = 2'd2,
		KIND_HEART  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		DRIVE_HOLD = 2'd0,
		DRIVE_ON   = 2'd1,
		DRIVE_OFF  = 2'd2,
		DRIVE_HOLD_ALT = 2'd3
	} drive_t;

	typedef enum logic {
		CFG_CONTROL_MODE = 1'b0,
		CFG_MANUAL_DRIVE = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic       frame_end;
		kind_t      update_kind;
		logic [7:0] respiration_rate;
		logic [2:0] breath_code;
		logic [7:0] heart_rate_value;
		logic       alarm_led;
	} result_t;

endpackage

@@ sv/vital_sign_frame_decoder.sv @@
// Vital sign radar frame decoder, top level.
// Depends on vsfd_pkg and assert_macros.svh.
//
// Takes one serial byte per request on s_* and returns one result per byte on m_*.
// The frame parser and report decode are a single combinational pass from the
// state registers into a two-entry output buffer, so a byte is accepted every
// cycle while the output buffer has room, including while one result waits on a
// stalled m_tready. Frames open on 0x55, close after the length byte says so;
// m_tlast marks the closing byte, m_tuser carries the update kind. control_mode
// and manual_drive are written through cfg_* by the user while idle; not enforced.
`include "assert_macros.svh"

module vital_sign_frame_decoder (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [7:0]                   s_tdata,   // [7:0] rx_byte
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// [7:0] respiration_rate, [10:8] breath_code, [18:11] heart_rate_value,
	// [19] alarm_led, [23:20] zero
	output logic [vsfd_pkg::TDATA_W-1:0] m_tdata,
	output logic                         m_tlast,   // frame_end
	output logic [1:0]                   m_tuser,   // [1:0] update_kind
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [1:0]                   cfg_data
);

	logic       in_frame_q;
	logic [7:0] byte_count_q;
	logic [7:0] frame_length_q;
	logic [7:0] cap_q [vsfd_pkg::CAP_DEPTH];
	logic [7:0] resp_rate_q;
	logic [2:0] breath_code_q;
	logic [7:0] pulse_rate_q;
	logic       led_q;
	logic       control_mode_q;
	logic [1:0] manual_drive_q;

	logic       accept;
	logic       start;
	logic       open_byte;
	logic       close;
	logic [7:0] eff_len;
	logic [7:0] cap_n [vsfd_pkg::CAP_DEPTH];
	logic [7:0] resp_rate_n;
	logic [2:0] breath_code_n;
	logic [7:0] pulse_rate_n;
	logic       led_n;
	vsfd_pkg::kind_t kind_n;
	vsfd_pkg::result_t res_n;

	vsfd_pkg::result_t out_q;
	vsfd_pkg::result_t skid_q;
	logic       out_valid_q;
	logic       skid_valid_q;
	logic       out_fire;

	assign s_tready = !skid_valid_q;
	assign accept   = s_tvalid && s_tready;
	assign out_fire = out_valid_q && m_tready;

	assign start     = !in_frame_q && (s_tdata == vsfd_pkg::SYNC_BYTE);
	assign open_byte = in_frame_q && (byte_count_q != vsfd_pkg::COUNT_MAX);
	assign eff_len   = (byte_count_q == 8'd1) ? s_tdata : frame_length_q;
	assign close     = open_byte && (byte_count_q == eff_len);

	always_comb begin
		for (int i = 0; i < vsfd_pkg::CAP_DEPTH; i++) begin
			if (start) begin
				cap_n[i] = 8'd0;
			end else if (open_byte && byte_count_q == 8'(vsfd_pkg::CAP_FIRST + i)) begin
				cap_n[i] = s_tdata;
			end else begin
				cap_n[i] = cap_q[i];
			end
		end
	end

	always_comb begin
		resp_rate_n   = resp_rate_q;
		breath_code_n = breath_code_q;
		pulse_rate_n  = pulse_rate_q;
		kind_n        = vsfd_pkg::KIND_NONE;
		if (close && cap_n[0] == vsfd_pkg::CLASS_VITAL) begin
			priority if (cap_n[1] == vsfd_pkg::GROUP_RESP) begin
				priority if (cap_n[2] == vsfd_pkg::ITEM_RATE) begin
					resp_rate_n = cap_n[3];
					kind_n      = vsfd_pkg::KIND_RESP;
				end else if (cap_n[2] == vsfd_pkg::ITEM_BREATH) begin
					if (cap_n[3] >= 8'd1 && cap_n[3] <= 8'd5) begin
						breath_code_n = cap_n[3][2:0];
					end
					kind_n = vsfd_pkg::KIND_BREATH;
				end else begin
					kind_n = vsfd_pkg::KIND_NONE;
				end
			end else if (cap_n[1] == vsfd_pkg::GROUP_HEART) begin
				if (cap_n[2] == vsfd_pkg::ITEM_RATE) begin
					pulse_rate_n = cap_n[3];
				end
				kind_n = vsfd_pkg::KIND_HEART;
			end else begin
				kind_n = vsfd_pkg::KIND_NONE;
			end
		end
	end

	// LED: breath code drives it in auto mode, the command in manual mode
	always_comb begin
		led_n = led_q;
		if (!control_mode_q) begin
			priority if (breath_code_n == 3'd1 || breath_code_n == 3'd5) begin
				led_n = 1'b1;
			end else if (breath_code_n >= 3'd2 && breath_code_n <= 3'd4) begin
				led_n = 1'b0;
			end else begin
				led_n = led_q;
			end
		end else begin
			unique case (vsfd_pkg::drive_t'(manual_drive_q))
				vsfd_pkg::DRIVE_ON:  led_n = 1'b1;
				vsfd_pkg::DRIVE_OFF: led_n = 1'b0;
				default:             led_n = led_q;
			endcase
		end
	end

	always_comb begin
		res_n.frame_end        = close;
		res_n.update_kind      = kind_n;
		res_n.respiration_rate = resp_rate_n;
		res_n.breath_code      = breath_code_n;
		res_n.heart_rate_value = pulse_rate_n;
		res_n.alarm_led        = led_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q     <= 1'b0;
			byte_count_q   <= 8'd0;
			frame_length_q <= 8'd0;
			for (int i = 0; i < vsfd_pkg::CAP_DEPTH; i++) begin
				cap_q[i] <= 8'd0;
			end
			resp_rate_q    <= 8'd0;
			breath_code_q  <= 3'd0;
			pulse_rate_q   <= 8'd0;
			led_q          <= 1'b0;
		end else if (accept) begin
			if (start) begin
				in_frame_q   <= 1'b1;
				byte_count_q <= 8'd1;
			end else if (open_byte) begin
				byte_count_q <= byte_count_q + 8'd1;
				if (close) begin
					in_frame_q <= 1'b0;
				end
			end
			if (open_byte && byte_count_q == 8'd1) begin
				frame_length_q <= s_tdata;
			end
			for (int i = 0; i < vsfd_pkg::CAP_DEPTH; i++) begin
				cap_q[i] <= cap_n[i];
			end
			resp_rate_q   <= resp_rate_n;
			breath_code_q <= breath_code_n;
			pulse_rate_q  <= pulse_rate_n;
			led_q         <= led_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_mode_q <= 1'b0;
			manual_drive_q <= 2'd0;
		end else if (cfg_we) begin
			unique case (vsfd_pkg::cfg_index_t'(cfg_index))
				vsfd_pkg::CFG_CONTROL_MODE: control_mode_q <= cfg_data[0];
				vsfd_pkg::CFG_MANUAL_DRIVE: manual_drive_q <= cfg_data;
			endcase
		end
	end

	// two-entry output buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_fire) begin
				skid_valid_q <= 1'b0;
			end
		end else if (accept) begin
			if (out_valid_q && !out_fire) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_fire) begin
				out_q <= skid_q;
			end
		end else if (accept) begin
			if (out_valid_q && !out_fire) begin
				skid_q <= res_n;
			end else begin
				out_q <= res_n;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_q.frame_end;
	assign m_tuser  = out_q.update_kind;
	assign m_tdata  = {4'd0, out_q.alarm_led, out_q.heart_rate_value,
		out_q.breath_code, out_q.respiration_rate};

	`VSFD_ASSERT(a_skid_needs_out, !skid_valid_q || out_valid_q)
	`VSFD_ASSERT(a_kind_only_at_end, !m_tvalid || m_tuser == 2'd0 || m_tlast)
	`VSFD_ASSERT(a_open_has_count, !in_frame_q || byte_count_q != 8'd0)
	`VSFD_ASSERT_NEXT(a_skid_refills_out, out_fire && skid_valid_q, out_valid_q && !skid_valid_q)

endmodule

@@ verif/tb_vital_sign_frame_decoder.sv @@
// Self-checking bench for vital_sign_frame_decoder: radar byte streams in, one report per byte out.
// A decode tracker class predicts every report from the accepted requests and compares fields.
// Depends on vsfd_pkg and the decoder RTL.
`timescale 1ns / 100ps

module tb_vital_sign_frame_decoder;
	import vsfd_pkg::*;

	class frame_decode_checker;
		logic       in_frame;
		logic [7:0] byte_count;
		logic [7:0] frame_len;
		logic [7:0] capture[CAP_DEPTH];
		logic [7:0] resp_rate;
		logic [2:0] breath;
		logic [7:0] pulse_rate;
		logic       led;
		logic       manual_mode;
		drive_t     drive;
		result_t    expected_reports[$];
		int         errors;
		int         frames_closed;
		int         kind_seen[4];

		function new();
			in_frame = 1'b0;
			byte_count = '0;
			frame_len = '0;
			foreach (capture[i]) capture[i] = '0;
			resp_rate = '0;
			breath = '0;
			pulse_rate = '0;
			led = 1'b0;
			manual_mode = 1'b0;
			drive = DRIVE_HOLD;
			errors = 0;
			frames_closed = 0;
			foreach (kind_seen[i]) kind_seen[i] = 0;
		endfunction

		function void write_reg(cfg_index_t idx, logic [1:0] value);
			if (idx == CFG_CONTROL_MODE) begin
				manual_mode = value[0];
			end else begin
				drive = drive_t'(value);
			end
		endfunction

		function void take_byte(logic [7:0] b);
			result_t    r;
			logic [7:0] pos;
			r = '0;
			r.update_kind = KIND_NONE;
			if (!in_frame) begin
				if (b == SYNC_BYTE) begin
					in_frame = 1'b1;
					byte_count = 8'd1;
					foreach (capture[i]) capture[i] = '0;
				end
			end else if (byte_count < COUNT_MAX) begin
				pos = byte_count;
				byte_count = byte_count + 8'd1;
				if (pos == 8'd1)
					frame_len = b;
				if (pos >= CAP_FIRST && pos < CAP_FIRST + CAP_DEPTH)
					capture[pos - CAP_FIRST] = b;
				if (pos == frame_len) begin
					in_frame = 1'b0;
					r.frame_end = 1'b1;
					frames_closed++;
					if (capture[0] == CLASS_VITAL) begin
						if (capture[1] == GROUP_RESP) begin
							if (capture[2] == ITEM_RATE) begin
								resp_rate = capture[3];
								r.update_kind = KIND_RESP;
							end else if (capture[2] == ITEM_BREATH) begin
								if (capture[3] >= 8'd1 && capture[3] <= 8'd5)
									breath = capture[3][2:0];
								r.update_kind = KIND_BREATH;
							end
						end else if (capture[1] == GROUP_HEART) begin
							if (capture[2] == ITEM_RATE)
								pulse_rate = capture[3];
							r.update_kind = KIND_HEART;
						end
					end
					kind_seen[r.update_kind]++;
				end
			end
			if (!manual_mode) begin
				if (breath == 3'd1 || breath == 3'd5)
					led = 1'b1;
				else if (breath >= 3'd2 && breath <= 3'd4)
					led = 1'b0;
			end else begin
				if (drive == DRIVE_ON)
					led = 1'b1;
				else if (drive == DRIVE_OFF)
					led = 1'b0;
			end
			r.respiration_rate = resp_rate;
			r.breath_code = breath;
			r.heart_rate_value = pulse_rate;
			r.alarm_led = led;
			expected_reports.push_back(r);
		endfunction

		function void compare(string field, logic [7:0] exp_v, logic [7:0] act_v);
			if (act_v !== exp_v) begin
				$error("%s expected %0d actual %0d", field, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_report(result_t got);
			result_t exp_r;
			if (expected_reports.size() == 0) begin
				$error("report with no request pending");
				errors++;
				return;
			end
			exp_r = expected_reports.pop_front();
			compare("frame_end", 8'(exp_r.frame_end), 8'(got.frame_end));
			compare("update_kind", 8'(exp_r.update_kind), 8'(got.update_kind));
			compare("respiration_rate", exp_r.respiration_rate, got.respiration_rate);
			compare("breath_code", 8'(exp_r.breath_code), 8'(got.breath_code));
			compare("heart_rate_value", exp_r.heart_rate_value, got.heart_rate_value);
			compare("alarm_led", 8'(exp_r.alarm_led), 8'(got.alarm_led));
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [7:0]          s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	logic [TDATA_W-1:0]  m_tdata;
	logic                m_tlast;
	logic [1:0]          m_tuser;
	logic                cfg_we;
	logic                cfg_index;
	logic [1:0]          cfg_data;

	frame_decode_checker tracker;
	int                  sent_bytes;
	int                  burst_left;
	int                  settings_used;
	bit                  hold_req;
	bit                  hold_active;

	vital_sign_frame_decoder u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("simulation failed");
		$finish;
	end

	// requests and reports are both sampled at the edge, requests first
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				tracker.take_byte(s_tdata);
			if (m_tvalid && m_tready)
				tracker.check_report({m_tlast, m_tuser, m_tdata[7:0], m_tdata[10:8],
					m_tdata[18:11], m_tdata[19]});
		end
	end

	initial begin : receiver
		int mode;
		int left;
		mode = 0;
		left = 0;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_active = 1'b1;
				m_tready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_active = 1'b0;
			end
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(10, 80);
			end
			left--;
			case (mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= (left % 4 == 0);
				default: m_tready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
				: $urandom_range(1, 24);
			if (!hold_active) begin
				gap = $urandom_range(1, 6);
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		sent_bytes++;
	endtask

	task automatic send_report(input int len, input logic [7:0] p2, input logic [7:0] cls,
			input logic [7:0] grp, input logic [7:0] item, input logic [7:0] val);
		logic [7:0] b;
		send_byte(SYNC_BYTE);
		send_byte(8'(len));
		for (int p = 2; p <= len; p++) begin
			case (p)
				2: b = p2;
				3: b = cls;
				4: b = grp;
				5: b = item;
				6: b = val;
				default: b = 8'($urandom);
			endcase
			send_byte(b);
		end
	endtask

	// mostly well-formed reports with random content, some short, long or malformed
	task automatic send_random_frame();
		int         len;
		int         r;
		logic [7:0] b;
		logic [7:0] p2;
		logic [7:0] cls;
		logic [7:0] grp;
		logic [7:0] item;
		logic [7:0] val;
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 4)) begin
				b = 8'($urandom);
				if (b == SYNC_BYTE)
					b = ~b;
				send_byte(b);
			end
		end
		r = $urandom_range(0, 19);
		if (r < 14)
			len = $urandom_range(6, 9);
		else if (r < 18)
			len = $urandom_range(1, 5);
		else
			len = $urandom_range(10, 60);
		p2 = ($urandom_range(0, 3) == 0) ? SYNC_BYTE : 8'($urandom);
		cls = ($urandom_range(0, 7) == 0) ? 8'($urandom) : CLASS_VITAL;
		r = $urandom_range(0, 19);
		grp = (r < 9) ? GROUP_RESP : (r < 16) ? GROUP_HEART : 8'($urandom);
		r = $urandom_range(0, 19);
		item = (r < 9) ? ITEM_RATE : (r < 16) ? ITEM_BREATH : 8'($urandom);
		if (item == ITEM_BREATH && $urandom_range(0, 3) != 0)
			val = 8'($urandom_range(0, 7));
		else
			val = 8'($urandom);
		send_report(len, p2, cls, grp, item, val);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.write_reg(idx, value);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (tracker.expected_reports.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_setting(input logic mode, input logic [1:0] drv);
		drain();
		write_reg(CFG_CONTROL_MODE, {1'b0, mode});
		write_reg(CFG_MANUAL_DRIVE, drv);
		settings_used++;
	endtask

	initial begin : stimulus
		logic [1:0] drives[5];
		logic       modes[5];
		int         target;
		tracker = new();
		sent_bytes = 0;
		burst_left = 0;
		settings_used = 0;
		hold_req = 1'b0;
		hold_active = 1'b0;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_CONTROL_MODE;
		cfg_data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apply_setting(1'b0, DRIVE_HOLD);

		// directed: noise outside a frame, then each report kind and corner
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'hAA);
		send_report(6, 8'h00, CLASS_VITAL, GROUP_RESP, ITEM_RATE, 8'hFF);
		send_report(6, SYNC_BYTE, CLASS_VITAL, GROUP_RESP, ITEM_RATE, 8'h00);
		send_report(6, 8'h00, CLASS_VITAL, GROUP_RESP, ITEM_BREATH, 8'd1);
		send_report(6, 8'h00, CLASS_VITAL, GROUP_RESP, ITEM_BREATH, 8'd0);
		send_report(6, 8'h00, CLASS_VITAL, GROUP_RESP, ITEM_BREATH, 8'd7);
		send_report(6, 8'h00, CLASS_VITAL, GROUP_RESP, ITEM_BREATH, 8'd3);
		send_report(6, 8'h00, CLASS_VITAL, GROUP_RESP, ITEM_BREATH, 8'd5);
		send_report(6, 8'h00, CLASS_VITAL, GROUP_HEART, ITEM_RATE, 8'hFF);
		send_report(6, 8'h00, CLASS_VITAL, GROUP_HEART, 8'h02, 8'hAA);
		send_report(6, 8'h00, CLASS_VITAL, GROUP_HEART, ITEM_RATE, 8'h00);
		send_report(6, 8'h00, 8'h04, GROUP_RESP, ITEM_RATE, 8'h10);
		send_report(6, 8'h00, CLASS_VITAL, 8'h02, ITEM_RATE, 8'h10);
		send_report(6, 8'h00, CLASS_VITAL, GROUP_RESP, 8'h02, 8'h10);
		send_report(6, 8'h00, CLASS_VITAL, GROUP_RESP, ITEM_RATE, 8'h42);
		send_report(1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		send_report(2, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		// short frame: value position never arrives and must read as cleared
		send_report(5, 8'h00, CLASS_VITAL, GROUP_RESP, ITEM_RATE, 8'hEE);
		send_report(8, SYNC_BYTE, CLASS_VITAL, GROUP_RESP, ITEM_RATE, SYNC_BYTE);
		send_report(254, 8'h00, CLASS_VITAL, GROUP_HEART, ITEM_RATE, 8'hC8);

		modes = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0};
		drives = '{DRIVE_ON, DRIVE_OFF, DRIVE_HOLD_ALT, DRIVE_HOLD, DRIVE_OFF};
		for (int ph = 0; ph < 5; ph++) begin
			apply_setting(modes[ph], drives[ph]);
			if (ph == 0)
				hold_req = 1'b1;
			target = sent_bytes + 235;
			while (sent_bytes < target)
				send_random_frame();
		end

		// a frame of length 0 or 255 never closes and locks the parser up
		send_byte(SYNC_BYTE);
		send_byte(($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF);
		repeat (300)
			send_byte(($urandom_range(0, 7) == 0) ? SYNC_BYTE : 8'($urandom));
		drain();

		$display("covered %0d bytes over %0d settings, %0d frames closed", sent_bytes,
			settings_used, tracker.frames_closed);
		$display("updates: %0d none, %0d rate, %0d breath, %0d heart",
			tracker.kind_seen[KIND_NONE], tracker.kind_seen[KIND_RESP],
			tracker.kind_seen[KIND_BREATH], tracker.kind_seen[KIND_HEART]);
		if (tracker.errors == 0 && tracker.expected_reports.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
